/* design/ffsa_pkg.sv */
// Shared types and codes for the first-fit segment allocator.
package ffsa_pkg;

  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int SIZE_W  = 21;
  localparam int ADDR_W  = 20;
  localparam int PID_W   = 16;
  localparam int TIME_W  = 32;
  localparam int USAGE_W = 7;
  localparam int NUM_W   = 28;

  localparam logic [SIZE_W-1:0] RESET_SIZE = 21'd2048;
  localparam logic [SIZE_W-1:0] MEM_LIMIT  = 21'd1048576;

  localparam logic [2:0] KIND_FIT   = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_EVICT = 3'd2;
  localparam logic [2:0] KIND_TOUCH = 3'd3;
  localparam logic [2:0] KIND_LRU   = 3'd4;
  localparam logic [2:0] KIND_USAGE = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] seg_start;
    logic [SIZE_W-1:0] seg_len;
    logic              seg_used;
    logic [PID_W-1:0]  seg_owner;
    logic [TIME_W-1:0] seg_last;
  } seg_entry_t;

endpackage

/* design/ffsa_ram.sv */
// Segment table memory: one write port, one registered read port.
module ffsa_ram import ffsa_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic       clk,
  input  logic       we,
  input  logic [AW-1:0] waddr,
  input  seg_entry_t wdata,
  input  logic [AW-1:0] raddr,
  output seg_entry_t rdata
);

  seg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ffsa_div.sv */
// Restoring divider, one quotient bit per cycle.
module ffsa_div import ffsa_pkg::*; #(
  parameter int NW = NUM_W,
  parameter int DW = SIZE_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          fin
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW:0]      rem;
  logic [NW-1:0]    acc;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DW:0]      trial;
  logic             take;

  assign trial = {rem[DW-1:0], acc[NW-1]};
  assign take  = trial >= {1'b0, dvs};
  assign quo   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(NW);
        acc <= num;
        dvs <= den;
        rem <= '0;
      end else if (run) begin
        rem <= take ? trial - {1'b0, dvs} : trial;
        acc <= {acc[NW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/first_fit_segment_allocator_unit.sv */
// Top level of the first-fit segment allocator: sequencer around the segment table.
//
// Use: drive kind, proc_id, size, start_req and time_now with start high; the
// operation is taken at a clock edge where start is high and busy is low. busy
// stays high until the result beat: done is high for exactly one cycle with
// found, address, victim_id, usage_percent and status valid in that cycle.
// The receiver cannot stall; results are valid only while done is high.
// Steps of each operation, n = segments in the table:
//   query fit/touch/least recent: a scan of up to n entries
//   load: a scan, plus a move of the segments above the hole on a split
//   evict: a scan of all n entries, plus a move of entries down when neighbors merge
//   usage: the scan, then a 28-step restoring divider
// The scan is paced by the single read port of the table memory, one entry a cycle.
// cfg_we writes memory_size (0 taken as 1, clamped to 1048576) and rebuilds the
// table as one hole; write it only while busy is low. Reset gives size 2048.
// Table reset needs no clearing pass: only entry 0 is defined after reset, held
// by a flag until first written.
module first_fit_segment_allocator_unit import ffsa_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic [PID_W-1:0]   proc_id,
  input  logic [SIZE_W-1:0]  size,
  input  logic [ADDR_W-1:0]  start_req,
  input  logic [TIME_W-1:0]  time_now,
  output logic               done,
  output logic               found,
  output logic [ADDR_W-1:0]  address,
  output logic [PID_W-1:0]   victim_id,
  output logic [USAGE_W-1:0] usage_percent,
  output logic [1:0]         status,
  input  logic               cfg_we,
  input  logic [SIZE_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_LDCHK = 4'd2;
  localparam logic [3:0] S_MOVE  = 4'd3;
  localparam logic [3:0] S_LDWR1 = 4'd4;
  localparam logic [3:0] S_LDWR0 = 4'd5;
  localparam logic [3:0] S_EVFIX = 4'd6;
  localparam logic [3:0] S_DIVGO = 4'd7;
  localparam logic [3:0] S_DIVWT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] mv_ret;

  // table bookkeeping
  logic [SIZE_W-1:0] msize;
  logic [CW-1:0]     count;
  logic              init_flag;
  logic              ovr;

  // captured operation
  logic [2:0]        kind_q;
  logic [PID_W-1:0]  pid_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] start_q;
  logic [TIME_W-1:0] now_q;

  // scan / move pipeline: read issued one cycle, used the next
  logic [CW-1:0] idx;
  logic          pv;
  logic [AW-1:0] pd;
  logic [CW-1:0] mv_src;
  logic [CW-1:0] mv_left;
  logic          mv_up;
  logic [1:0]    mv_n;

  // load
  logic [AW-1:0]     hi;
  logic [SIZE_W-1:0] hlen;
  logic [SIZE_W-1:0] hrem;

  // evict
  logic [AW-1:0]     t_idx;
  logic              ph, nh, last_hit, prev_used;
  logic [SIZE_W-1:0] plen, tlen, nlen, prev_len;
  logic [ADDR_W-1:0] pstart, tstart, prev_start;

  // least recent and usage
  logic [TIME_W-1:0] best;
  logic [SIZE_W-1:0] used_sum;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  seg_entry_t    wdata, rdata, ent, init_ent;

  logic              scan_issue, mv_issue, hit_own;
  logic [SIZE_W-1:0] merge_len, ld_rem;
  logic [SIZE_W:0]   split_sum;
  logic [NUM_W-1:0]  div_num, div_q;
  logic              div_go, div_fin;

  logic          found_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [PID_W-1:0]   victim_r;
  logic [USAGE_W-1:0] usage_r;
  logic [1:0]         status_r;

  ffsa_ram #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ffsa_div #(.NW(NUM_W), .DW(SIZE_W)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(div_num), .den(msize),
    .quo(div_q), .fin(div_fin)
  );

  // entry 0 reads as the initial hole until it is first written
  always_comb begin
    init_ent           = '0;
    init_ent.seg_len   = msize;
    ent                = ovr ? init_ent : rdata;
  end

  assign scan_issue = (state == S_SCAN) && (idx < count);
  assign mv_issue   = (state == S_MOVE) && (mv_left != '0);
  assign hit_own    = pv && ent.seg_used && (ent.seg_owner == pid_q);
  assign merge_len  = tlen + (ph ? plen : '0) + (nh ? nlen : '0);
  assign ld_rem     = hlen - size_q;
  assign split_sum  = {1'b0, start_q} + {1'b0, size_q};
  assign div_go     = (state == S_DIVGO);
  assign div_num    = ({7'b0, used_sum} << 6) + ({7'b0, used_sum} << 5)
                    + ({7'b0, used_sum} << 2) + {7'b0, msize} - NUM_W'(1);

  assign raddr = (state == S_MOVE) ? mv_src[AW-1:0] : idx[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = pd;
    wdata = ent;
    unique case (state)
      S_SCAN: begin
        if (kind_q == KIND_TOUCH && hit_own) begin
          we             = 1'b1;
          wdata.seg_last = now_q;
        end
      end
      S_MOVE: begin
        we = pv;
      end
      S_LDWR1: begin
        we              = 1'b1;
        waddr           = hi + 1'b1;
        wdata           = '0;
        wdata.seg_start = split_sum[ADDR_W-1:0];
        wdata.seg_len   = hrem;
      end
      S_LDWR0: begin
        we              = 1'b1;
        waddr           = hi;
        wdata.seg_start = start_q;
        wdata.seg_len   = size_q;
        wdata.seg_used  = 1'b1;
        wdata.seg_owner = pid_q;
        wdata.seg_last  = now_q;
      end
      S_EVFIX: begin
        we              = 1'b1;
        waddr           = ph ? t_idx - 1'b1 : t_idx;
        wdata           = '0;
        wdata.seg_start = ph ? pstart : tstart;
        wdata.seg_len   = merge_len;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      msize     <= RESET_SIZE;
      count     <= CW'(1);
      init_flag <= 1'b1;
      ovr       <= 1'b0;
      pv        <= 1'b0;
    end else begin
      ovr <= init_flag && (raddr == '0);
      if (we && waddr == '0) begin
        init_flag <= 1'b0;
      end
      pv <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_wdata == '0) begin
              msize <= SIZE_W'(1);
            end else if (cfg_wdata > MEM_LIMIT) begin
              msize <= MEM_LIMIT;
            end else begin
              msize <= cfg_wdata;
            end
            count     <= CW'(1);
            init_flag <= 1'b1;
          end else if (start) begin
            kind_q    <= kind;
            pid_q     <= proc_id;
            size_q    <= size;
            start_q   <= start_req;
            now_q     <= time_now;
            found_r   <= 1'b0;
            addr_r    <= '0;
            victim_r  <= '0;
            usage_r   <= '0;
            status_r  <= STAT_NONE;
            idx       <= '0;
            last_hit  <= 1'b0;
            prev_used <= 1'b1;
            used_sum  <= '0;
            if (kind == KIND_FIT || kind == KIND_LOAD || kind == KIND_EVICT ||
                kind == KIND_TOUCH || kind == KIND_LRU || kind == KIND_USAGE) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            idx <= idx + 1'b1;
            pv  <= 1'b1;
            pd  <= idx[AW-1:0];
          end
          if (pv) begin
            prev_used  <= ent.seg_used;
            prev_len   <= ent.seg_len;
            prev_start <= ent.seg_start;
            last_hit   <= hit_own;
            if (ent.seg_used) begin
              used_sum <= used_sum + ent.seg_len;
            end
          end
          case (kind_q)
            KIND_FIT: begin
              if (pv && !ent.seg_used && ent.seg_len >= size_q) begin
                found_r  <= 1'b1;
                addr_r   <= ent.seg_start;
                status_r <= STAT_OK;
                state    <= S_DONE;
              end else if (!pv && !scan_issue) begin
                state <= S_DONE;
              end
            end
            KIND_LOAD: begin
              if (pv && !ent.seg_used && ent.seg_start == start_q) begin
                hi    <= pd;
                hlen  <= ent.seg_len;
                state <= S_LDCHK;
              end else if (!pv && !scan_issue) begin
                status_r <= STAT_BAD;
                state    <= S_DONE;
              end
            end
            KIND_EVICT: begin
              if (hit_own) begin
                found_r <= 1'b1;
                t_idx   <= pd;
                ph      <= (pd != '0) && !prev_used;
                plen    <= prev_len;
                pstart  <= prev_start;
                tlen    <= ent.seg_len;
                tstart  <= ent.seg_start;
                nh      <= 1'b0;
                nlen    <= '0;
              end else if (pv && last_hit) begin
                nh   <= !ent.seg_used;
                nlen <= ent.seg_len;
              end
              if (!pv && !scan_issue) begin
                state <= found_r ? S_EVFIX : S_DONE;
              end
            end
            KIND_TOUCH: begin
              if (hit_own) begin
                found_r  <= 1'b1;
                status_r <= STAT_OK;
              end
              if (!pv && !scan_issue) begin
                state <= S_DONE;
              end
            end
            KIND_LRU: begin
              if (pv && ent.seg_used && (!found_r || ent.seg_last < best)) begin
                best     <= ent.seg_last;
                victim_r <= ent.seg_owner;
                found_r  <= 1'b1;
                status_r <= STAT_OK;
              end
              if (!pv && !scan_issue) begin
                state <= S_DONE;
              end
            end
            default: begin
              if (!pv && !scan_issue) begin
                status_r <= STAT_OK;
                state    <= S_DIVGO;
              end
            end
          endcase
        end
        S_LDCHK: begin
          hrem <= ld_rem;
          if (size_q == '0 || size_q > hlen) begin
            status_r <= STAT_BAD;
            state    <= S_DONE;
          end else if (ld_rem != '0 && count >= CW'(MAX_SEGMENTS)) begin
            status_r <= STAT_FULL;
            state    <= S_DONE;
          end else if (ld_rem != '0) begin
            // open a slot above the hole: move entries up, top first
            mv_src  <= count - 1'b1;
            mv_left <= count - CW'(hi) - 1'b1;
            mv_up   <= 1'b1;
            mv_ret  <= S_LDWR1;
            state   <= S_MOVE;
          end else begin
            state <= S_LDWR0;
          end
        end
        S_MOVE: begin
          if (mv_issue) begin
            mv_src  <= mv_up ? mv_src - 1'b1 : mv_src + 1'b1;
            mv_left <= mv_left - 1'b1;
            pv      <= 1'b1;
            pd      <= mv_up ? mv_src[AW-1:0] + 1'b1 : mv_src[AW-1:0] - AW'(mv_n);
          end else if (!pv) begin
            state <= mv_ret;
          end
        end
        S_LDWR1: begin
          count <= count + 1'b1;
          state <= S_LDWR0;
        end
        S_LDWR0: begin
          found_r  <= 1'b1;
          status_r <= STAT_OK;
          state    <= S_DONE;
        end
        S_EVFIX: begin
          status_r <= STAT_OK;
          mv_up    <= 1'b0;
          mv_ret   <= S_DONE;
          if (ph) begin
            // drop the freed block (and the hole above it) into the lower hole
            mv_n    <= nh ? 2'd2 : 2'd1;
            mv_src  <= CW'(t_idx) + (nh ? CW'(2) : CW'(1));
            mv_left <= count - CW'(t_idx) - (nh ? CW'(2) : CW'(1));
            count   <= count - (nh ? CW'(2) : CW'(1));
            state   <= S_MOVE;
          end else if (nh) begin
            mv_n    <= 2'd1;
            mv_src  <= CW'(t_idx) + CW'(2);
            mv_left <= count - CW'(t_idx) - CW'(2);
            count   <= count - 1'b1;
            state   <= S_MOVE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIVGO: begin
          state <= S_DIVWT;
        end
        S_DIVWT: begin
          if (div_fin) begin
            usage_r <= div_q[USAGE_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign found         = found_r;
  assign address       = addr_r;
  assign victim_id     = victim_r;
  assign usage_percent = usage_r;
  assign status        = status_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("result beat not followed by idle");

  a_load_ok_found: assert property (@(posedge clk) disable iff (rst)
    done && kind_q == KIND_LOAD && status == STAT_OK |-> found)
    else $error("successful load without found");

  a_usage_bound: assert property (@(posedge clk) disable iff (rst)
    done && kind_q == KIND_USAGE |-> usage_percent <= USAGE_W'(100))
    else $error("usage above 100");
`endif

endmodule
